### hdl/mrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrt_pkg;

	localparam int NIB_W     = 4;
	localparam int NIB_CNT   = 8;
	localparam int CNT_W     = 32;
	localparam int ITEMS_W   = 3;
	localparam int TOT_W     = 16;
	localparam int LAM_W     = 16;
	localparam int MODE_W    = 3;
	localparam int STATUS_W  = 3;
	localparam int SLOT_W    = 6;
	localparam int TLEN_W    = 7;
	localparam int DIV_X_W   = 17;
	localparam int RECIP_W   = 18;
	localparam int RECIP_SH  = 17;

	localparam logic [MODE_W-1:0] MODE_PROBE      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ENTER      = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLR_SLOTS  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CLR_TOTALS = 3'd5;

	localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_BAD_SLOT  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 3'd4;

	localparam logic REG_AVAIL = 1'b0;
	localparam logic REG_TLEN  = 1'b1;

	typedef struct packed {
		logic [ITEMS_W-1:0] items;
		logic [CNT_W-1:0]   counters;
	} slot_entry_t;

	typedef struct packed {
		logic             fits;
		logic             ovf;
		logic             under;
		logic [CNT_W-1:0] sum;
		logic [CNT_W-1:0] diff;
	} alu_res_t;

	// floor(2^17 / a); zero for a zero divisor, which is never used
	function automatic logic [RECIP_W-1:0] recip(input logic [NIB_W-1:0] a);
		logic [RECIP_W-1:0] r;
		unique case (a)
			4'd1:    r = 18'd131072;
			4'd2:    r = 18'd65536;
			4'd3:    r = 18'd43690;
			4'd4:    r = 18'd32768;
			4'd5:    r = 18'd26214;
			4'd6:    r = 18'd21845;
			4'd7:    r = 18'd18724;
			4'd8:    r = 18'd16384;
			4'd9:    r = 18'd14563;
			4'd10:   r = 18'd13107;
			4'd11:   r = 18'd11915;
			4'd12:   r = 18'd10922;
			4'd13:   r = 18'd10082;
			4'd14:   r = 18'd9362;
			4'd15:   r = 18'd8738;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### hdl/modulo_reservation_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Modulo reservation table. Slot usage counters and item counts live in one
// synchronous memory; each transaction is read in the cycle it is accepted,
// updated and written back in the next, and its result is then loaded into
// the output register once that register is empty or being read. The lambda
// estimate is kept in a register and recomputed only when the totals change
// (enter totals with is_scheduled set, clear totals) or availability is
// written: the lambda unit handles one resource per cycle through a
// pipelined reciprocal divide, and those transactions wait in a lambda state
// until it is done; after an availability write s_tready stays low until the
// recompute finishes. Clear slots acts at once through per-slot valid bits;
// there is no clearing pass.
module modulo_reservation_table
	import mrt_pkg::*;
#(
	parameter int NUM_RESOURCES = 8,
	parameter int MAX_SLOTS     = 64,
	parameter int MAX_ITEMS     = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// mode[2:0], slot[8:3], requirements[40:9], zero[47:41]
	input  wire logic [47:0] s_tdata,
	// is_scheduled[0]
	input  wire logic        s_tuser,
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// accepted[0], status[3:1], lambda_estimate[19:4], slot_item_count[22:20], zero[23]
	output logic [23:0]      m_tdata
);

	localparam int NR = (NUM_RESOURCES > NIB_CNT) ? NIB_CNT : NUM_RESOURCES;
	localparam int AW = $clog2(MAX_SLOTS);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MOD  = 2'd1;
	localparam logic [1:0] S_LAM  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0]               state_q;
	logic [CNT_W-1:0]         avail_q;
	logic [TLEN_W-1:0]        tlen_q;
	logic [MODE_W-1:0]        mode_q;
	logic [SLOT_W-1:0]        slot_q;
	logic [CNT_W-1:0]         req_q;
	logic                     sched_q;
	logic                     acc_q;
	logic [STATUS_W-1:0]      status_q;
	logic [ITEMS_W-1:0]       cnt_q;
	logic [NR-1:0][TOT_W-1:0] tot_q;
	logic                     lam_req_q;
	logic                     out_valid_q;
	logic [23:0]              out_data_q;

	logic                     in_fire;
	logic                     cfg_wr;
	logic                     lam_busy;
	logic                     lam_start;
	logic [LAM_W-1:0]         lambda;
	logic                     out_load;
	logic [SLOT_W-1:0]        in_slot;

	slot_entry_t              rd_entry;
	slot_entry_t              wr_entry;
	alu_res_t                 alu;
	logic                     slot_ok;
	logic                     acc_d;
	logic [STATUS_W-1:0]      status_d;
	logic [ITEMS_W-1:0]       cnt_d;
	logic                     wr_d;
	logic                     clr_slots_d;
	logic                     tot_add_d;
	logic                     tot_clr_d;
	logic [NR-1:0][TOT_W-1:0] tot_sum;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == REG_TLEN) ? 32'(tlen_q) : avail_q;

	assign in_slot  = s_tdata[8:3];
	assign s_tready = (state_q == S_IDLE) && !lam_req_q && !lam_busy;
	assign in_fire  = s_tvalid & s_tready;
	assign lam_start = lam_req_q & ~lam_busy;

	mrt_slot_store #(
		.DEPTH (MAX_SLOTS),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_fire),
		.rd_addr (AW'(in_slot)),
		.rd_data (rd_entry),
		.wr_en   ((state_q == S_MOD) && wr_d),
		.wr_addr (AW'(slot_q)),
		.wr_data (wr_entry),
		.clear   ((state_q == S_MOD) && clr_slots_d)
	);

	mrt_slot_alu #(
		.NR (NR)
	) u_alu (
		.counters (rd_entry.counters),
		.req      (req_q),
		.avail    (avail_q),
		.res      (alu)
	);

	mrt_lambda #(
		.NR (NR)
	) u_lambda (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lam_start),
		.avail  (avail_q),
		.totals (tot_q),
		.busy   (lam_busy),
		.lambda (lambda)
	);

	assign slot_ok = ({1'b0, slot_q} < tlen_q) && (9'(slot_q) < 9'(MAX_SLOTS));

	always_comb begin
		acc_d       = 1'b0;
		status_d    = STAT_OK;
		wr_d        = 1'b0;
		wr_entry    = rd_entry;
		clr_slots_d = 1'b0;
		tot_add_d   = 1'b0;
		tot_clr_d   = 1'b0;
		if ((mode_q == MODE_PROBE || mode_q == MODE_INSERT || mode_q == MODE_REMOVE)
				&& !slot_ok) begin
			status_d = STAT_BAD_SLOT;
		end else begin
			unique case (mode_q)
				MODE_PROBE: begin
					acc_d = alu.fits;
				end
				MODE_INSERT: begin
					if (sched_q) begin
						acc_d = alu.fits;
						if (rd_entry.items >= ITEMS_W'(MAX_ITEMS)) begin
							status_d = STAT_FULL;
						end else if (alu.ovf) begin
							status_d = STAT_OVERFLOW;
						end else begin
							wr_d              = 1'b1;
							wr_entry.items    = rd_entry.items + ITEMS_W'(1);
							wr_entry.counters = alu.sum;
						end
					end
				end
				MODE_REMOVE: begin
					if (rd_entry.items == '0 || alu.under) begin
						status_d = STAT_UNDERFLOW;
					end else begin
						wr_d              = 1'b1;
						wr_entry.items    = rd_entry.items - ITEMS_W'(1);
						wr_entry.counters = alu.diff;
					end
				end
				MODE_ENTER: begin
					tot_add_d = sched_q;
				end
				MODE_CLR_SLOTS: begin
					clr_slots_d = 1'b1;
				end
				MODE_CLR_TOTALS: begin
					tot_clr_d = 1'b1;
				end
				default: begin
				end
			endcase
		end
		cnt_d = (slot_ok && !clr_slots_d) ? wr_entry.items : '0;
	end

	// saturating add of each requirement nibble into its total
	always_comb begin
		logic [TOT_W:0] s;
		for (int r = 0; r < NR; r++) begin
			s = (TOT_W+1)'(tot_q[r]) + (TOT_W+1)'(req_q[NIB_W*r +: NIB_W]);
			tot_sum[r] = s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
		end
	end

	assign out_load = (state_q == S_OUT) && (!out_valid_q || m_tready);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q  <= s_tdata[2:0];
			slot_q  <= in_slot;
			req_q   <= s_tdata[40:9];
			sched_q <= s_tuser;
		end
		if (state_q == S_MOD) begin
			acc_q    <= acc_d;
			status_q <= status_d;
			cnt_q    <= cnt_d;
		end
		if (out_load) begin
			out_data_q <= {1'b0, cnt_q, lambda, status_q, acc_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			avail_q     <= 32'h1111_1111;
			tlen_q      <= TLEN_W'(1);
			tot_q       <= '0;
			lam_req_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == REG_AVAIL) begin
					avail_q <= pwdata;
				end else begin
					tlen_q <= pwdata[TLEN_W-1:0];
				end
			end

			if ((cfg_wr && paddr[2] == REG_AVAIL)
					|| (state_q == S_MOD && (tot_add_d || tot_clr_d))) begin
				lam_req_q <= 1'b1;
			end else if (lam_start) begin
				lam_req_q <= 1'b0;
			end

			if (state_q == S_MOD) begin
				if (tot_clr_d) begin
					tot_q <= '0;
				end else if (tot_add_d) begin
					tot_q <= tot_sum;
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					state_q <= (tot_add_d || tot_clr_d) ? S_LAM : S_OUT;
				end
				S_LAM: begin
					if (!lam_req_q && !lam_busy) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

### hdl/mrt_slot_store.sv
`timescale 1ns / 1ps
`default_nettype none

module mrt_slot_store
	import mrt_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output slot_entry_t      rd_data,
	input  wire logic        wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  slot_entry_t      wr_data,
	input  wire logic        clear
);

	slot_entry_t      mem [DEPTH];
	slot_entry_t      rd_q;
	logic             rd_vld_q;
	logic [DEPTH-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// an entry not written since the last clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clear) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

### hdl/mrt_slot_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module mrt_slot_alu
	import mrt_pkg::*;
#(
	parameter int NR = 8
) (
	input  wire logic [CNT_W-1:0] counters,
	input  wire logic [CNT_W-1:0] req,
	input  wire logic [CNT_W-1:0] avail,
	output alu_res_t              res
);

	always_comb begin
		logic [NIB_W:0]   s5;
		logic [NIB_W-1:0] c;
		logic [NIB_W-1:0] q;
		logic [NIB_W-1:0] a;
		res.fits  = 1'b1;
		res.ovf   = 1'b0;
		res.under = 1'b0;
		res.sum   = counters;
		res.diff  = counters;
		for (int r = 0; r < NIB_CNT; r++) begin
			c  = counters[NIB_W*r +: NIB_W];
			q  = req[NIB_W*r +: NIB_W];
			a  = avail[NIB_W*r +: NIB_W];
			s5 = {1'b0, c} + {1'b0, q};
			if (r < NR) begin
				if (s5 > {1'b0, a}) begin
					res.fits = 1'b0;
				end
				if (s5[NIB_W]) begin
					res.ovf = 1'b1;
				end
				if (c < q) begin
					res.under = 1'b1;
				end
				res.sum[NIB_W*r +: NIB_W]  = s5[NIB_W-1:0];
				res.diff[NIB_W*r +: NIB_W] = c - q;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/mrt_lambda.sv
`timescale 1ns / 1ps
`default_nettype none

module mrt_lambda
	import mrt_pkg::*;
#(
	parameter int NR = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [CNT_W-1:0]          avail,
	input  wire logic [NR-1:0][TOT_W-1:0]  totals,
	output logic                           busy,
	output logic [LAM_W-1:0]               lambda
);

	localparam int IW    = (NR > 1) ? $clog2(NR) : 1;
	localparam int PW    = DIV_X_W + RECIP_W;
	localparam int PRODW = DIV_X_W + NIB_W;

	logic                 issue_q;
	logic [IW-1:0]        idx_q;
	logic                 v_s1;
	logic                 v_s2;
	logic [DIV_X_W-1:0]   x_s1;
	logic [NIB_W-1:0]     a_s1;
	logic [PW-1:0]        p_s1;
	logic [LAM_W-1:0]     q_s2;
	logic [LAM_W-1:0]     lam_q;

	logic [NIB_W-1:0]     a_cur;
	logic [DIV_X_W-1:0]   x_cur;
	logic [PW-1:0]        p_cur;
	logic [DIV_X_W-1:0]   q0;
	logic [PRODW-1:0]     qa;
	logic [PRODW-1:0]     rem;
	logic [DIV_X_W-1:0]   q_fix;

	// stage 1: ceil(t/a) = floor((t+a-1)/a), estimate by reciprocal
	assign a_cur = avail[NIB_W*idx_q +: NIB_W];
	assign x_cur = DIV_X_W'(totals[idx_q]) + DIV_X_W'(a_cur) - DIV_X_W'(1);
	assign p_cur = PW'(x_cur) * PW'(recip(a_cur));

	// stage 2: the estimate is low by at most one, correct it
	assign q0    = p_s1[RECIP_SH +: DIV_X_W];
	assign qa    = PRODW'(q0) * PRODW'(a_s1);
	assign rem   = PRODW'(x_s1) - qa;
	assign q_fix = (rem >= PRODW'(a_s1)) ? q0 + DIV_X_W'(1) : q0;

	always_ff @(posedge clk) begin
		x_s1 <= x_cur;
		a_s1 <= a_cur;
		p_s1 <= p_cur;
		q_s2 <= (a_s1 == '0) ? '0 : q_fix[LAM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			idx_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			lam_q   <= LAM_W'(1);
		end else begin
			v_s1 <= issue_q;
			v_s2 <= v_s1;
			if (start) begin
				issue_q <= 1'b1;
				idx_q   <= '0;
				lam_q   <= LAM_W'(1);
			end else begin
				if (issue_q) begin
					if (idx_q == IW'(NR - 1)) begin
						issue_q <= 1'b0;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				if (v_s2 && (q_s2 > lam_q)) begin
					lam_q <= q_s2;
				end
			end
		end
	end

	assign busy   = issue_q | v_s1 | v_s2;
	assign lambda = lam_q;

endmodule

`default_nettype wire

### tb/sv/tb_modulo_reservation_table.sv
`timescale 1ns / 1ps

module tb_modulo_reservation_table;
	import mrt_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int SLOT_DEPTH  = 64;
	localparam int MAX_FILL    = 4;
	localparam int BULK_ENTERS = 150;

	// modes 6 and 7 have no function in the block
	localparam logic [MODE_W-1:0] MODE_NOP_LO = 3'd6;
	localparam logic [MODE_W-1:0] MODE_NOP_HI = 3'd7;

	typedef struct packed {
		logic               hold_for_drain;
		logic               sched;
		logic [CNT_W-1:0]   req;
		logic [SLOT_W-1:0]  slot;
		logic [MODE_W-1:0]  mode;
	} slot_op_t;

	// same bit layout as m_tdata[22:0]
	typedef struct packed {
		logic [ITEMS_W-1:0]  count;
		logic [LAM_W-1:0]    lambda;
		logic [STATUS_W-1:0] status;
		logic                accepted;
	} slot_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	wire  [31:0] prdata;
	wire         pready;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	logic [47:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	wire         m_tvalid;
	logic        m_tready = 1'b0;
	wire  [23:0] m_tdata;

	// shadow of the table, totals and registers
	logic [CNT_W-1:0]   slot_use  [SLOT_DEPTH] = '{default: '0};
	logic [ITEMS_W-1:0] slot_fill [SLOT_DEPTH] = '{default: '0};
	logic [TOT_W-1:0]   res_total [NIB_CNT]    = '{default: '0};
	logic [CNT_W-1:0]   avail_shadow = 32'h1111_1111;
	logic [TLEN_W-1:0]  tlen_shadow  = 7'd1;

	slot_op_t     op_queue[$];
	slot_result_t pending_results[$];
	slot_op_t     shown_op;
	logic [CNT_W-1:0] last_insert [SLOT_DEPTH] = '{default: '0};

	bit calm       = 1'b0;
	bit took       = 1'b0;
	int send_gap   = 0;
	int sink_stall = 0;
	int error_cnt  = 0;
	int cycle_cnt  = 0;

	modulo_reservation_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic bit fits_slot(input logic [CNT_W-1:0] used, input logic [CNT_W-1:0] req);
		for (int r = 0; r < NIB_CNT; r++) begin
			if (int'(used[4*r +: 4]) + int'(req[4*r +: 4]) > int'(avail_shadow[4*r +: 4]))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [LAM_W-1:0] lambda_now();
		int best;
		int a;
		int q;
		best = 1;
		for (int r = 0; r < NIB_CNT; r++) begin
			a = int'(avail_shadow[4*r +: 4]);
			// skip resources with no units available
			if (a != 0) begin
				q = (int'(res_total[r]) + a - 1) / a;
				if (q > best)
					best = q;
			end
		end
		return best[LAM_W-1:0];
	endfunction

	function automatic slot_result_t apply_slot_op(input slot_op_t op);
		slot_result_t res;
		logic [CNT_W-1:0] cur;
		logic in_range;
		logic over;
		logic under;
		int sum;
		res = '0;
		cur = slot_use[op.slot];
		in_range = op.slot < tlen_shadow;
		over = 1'b0;
		under = slot_fill[op.slot] == '0;
		for (int r = 0; r < NIB_CNT; r++) begin
			if (int'(cur[4*r +: 4]) + int'(op.req[4*r +: 4]) > 15)
				over = 1'b1;
			if (cur[4*r +: 4] < op.req[4*r +: 4])
				under = 1'b1;
		end
		if (op.mode <= MODE_REMOVE && !in_range) begin
			res.status = STAT_BAD_SLOT;
		end else begin
			case (op.mode)
				MODE_PROBE: begin
					res.accepted = fits_slot(cur, op.req);
				end
				MODE_INSERT: begin
					if (op.sched) begin
						res.accepted = fits_slot(cur, op.req);
						if (slot_fill[op.slot] >= MAX_FILL) begin
							res.status = STAT_FULL;
						end else if (over) begin
							res.status = STAT_OVERFLOW;
						end else begin
							// no nibble carries, so a plain add is per-resource
							slot_use[op.slot] = cur + op.req;
							slot_fill[op.slot] = slot_fill[op.slot] + ITEMS_W'(1);
						end
					end
				end
				MODE_REMOVE: begin
					if (under) begin
						res.status = STAT_UNDERFLOW;
					end else begin
						slot_use[op.slot] = cur - op.req;
						slot_fill[op.slot] = slot_fill[op.slot] - ITEMS_W'(1);
					end
				end
				MODE_ENTER: begin
					if (op.sched) begin
						for (int r = 0; r < NIB_CNT; r++) begin
							sum = int'(res_total[r]) + int'(op.req[4*r +: 4]);
							res_total[r] = (sum > 65535) ? 16'hFFFF : sum[TOT_W-1:0];
						end
					end
				end
				MODE_CLR_SLOTS: begin
					for (int i = 0; i < SLOT_DEPTH; i++) begin
						slot_use[i] = '0;
						slot_fill[i] = '0;
					end
				end
				MODE_CLR_TOTALS: begin
					for (int r = 0; r < NIB_CNT; r++)
						res_total[r] = '0;
				end
				default: ;
			endcase
		end
		if (in_range)
			res.count = slot_fill[op.slot];
		res.lambda = lambda_now();
		return res;
	endfunction

	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// mostly sparse small nibbles so slots fill up without overflowing
	function automatic logic [CNT_W-1:0] random_req();
		logic [CNT_W-1:0] req;
		int pick;
		if ($urandom_range(0, 19) == 0)
			return $urandom;
		for (int r = 0; r < NIB_CNT; r++) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				req[4*r +: 4] = 4'd0;
			else if (pick < 9)
				req[4*r +: 4] = NIB_W'($urandom_range(1, 2));
			else
				req[4*r +: 4] = NIB_W'($urandom_range(0, 15));
		end
		return req;
	endfunction

	function automatic slot_op_t random_op(input int tlen);
		slot_op_t op;
		int lim;
		int pick;
		op = '0;
		lim = (tlen > SLOT_DEPTH) ? SLOT_DEPTH : tlen;
		pick = $urandom_range(0, 9);
		if (lim == 0 || pick >= 8)
			op.slot = SLOT_W'($urandom_range(0, SLOT_DEPTH - 1));
		else if (pick < 6)
			op.slot = SLOT_W'($urandom_range(0, (lim > 4) ? 3 : lim - 1));
		else
			op.slot = SLOT_W'($urandom_range(0, lim - 1));
		op.req = random_req();
		op.sched = $urandom_range(0, 9) != 0;
		op.hold_for_drain = $urandom_range(0, 99) == 0;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			op.mode = MODE_PROBE;
		end else if (pick < 50) begin
			op.mode = MODE_INSERT;
			last_insert[op.slot] = op.req;
		end else if (pick < 75) begin
			op.mode = MODE_REMOVE;
			// undo an earlier insert most of the time
			if ($urandom_range(0, 9) < 7)
				op.req = last_insert[op.slot];
		end else if (pick < 87) begin
			op.mode = MODE_ENTER;
		end else if (pick < 91) begin
			op.mode = MODE_CLR_SLOTS;
		end else if (pick < 95) begin
			op.mode = MODE_CLR_TOTALS;
		end else if (pick < 97) begin
			op.mode = MODE_NOP_LO;
		end else begin
			op.mode = MODE_NOP_HI;
		end
		return op;
	endfunction

	task automatic add_op(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot,
			input logic [CNT_W-1:0] req, input logic sched);
		op_queue.push_back('{hold_for_drain: 1'b0, sched: sched, req: req, slot: slot,
			mode: mode});
	endtask

	task automatic apb_write(input logic reg_idx, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {reg_idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (reg_idx == REG_AVAIL)
			avail_shadow = data;
		else
			tlen_shadow = data[TLEN_W-1:0];
		@(negedge clk);
		// read back the register just written
		if (reg_idx == REG_AVAIL)
			check_field("availability", int'(data), int'(prdata));
		else
			check_field("table_length", int'(data[TLEN_W-1:0]), int'(prdata));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_drained();
		while (op_queue.size() != 0 || pending_results.size() != 0 || s_tvalid)
			@(negedge clk);
	endtask

	task automatic set_config(input logic [31:0] avail, input logic [TLEN_W-1:0] tlen,
			input bit quiet);
		wait_drained();
		repeat (16) @(negedge clk);
		apb_write(REG_AVAIL, avail);
		apb_write(REG_TLEN, {25'b0, tlen});
		calm = quiet;
	endtask

	task automatic add_random(input int count);
		repeat (count)
			op_queue.push_back(random_op(int'(tlen_shadow)));
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			error_cnt++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// feed transactions and throttle the result side
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || took) begin
				if (send_gap != 0) begin
					send_gap = send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (op_queue.size() != 0 &&
						!(op_queue[0].hold_for_drain && pending_results.size() != 0)) begin
					shown_op = op_queue.pop_front();
					s_tdata <= {7'b0, shown_op.req, shown_op.slot, shown_op.mode};
					s_tuser <= shown_op.sched;
					s_tvalid <= 1'b1;
					send_gap = calm ? 0 : idle_len();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			if (sink_stall != 0) begin
				sink_stall = sink_stall - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					sink_stall = idle_len();
			end
		end
	end

	always @(posedge clk) begin
		slot_result_t want;
		slot_result_t got;
		cycle_cnt++;
		if (arst_n) begin
			took <= s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				pending_results.push_back(apply_slot_op(shown_op));
			if (m_tvalid && m_tready) begin
				got = slot_result_t'(m_tdata[22:0]);
				if (pending_results.size() == 0) begin
					error_cnt++;
					$display("%0t: unexpected result expected none actual %h", $time, m_tdata);
				end else begin
					want = pending_results.pop_front();
					check_field("accepted", int'(want.accepted), int'(got.accepted));
					check_field("status", int'(want.status), int'(got.status));
					check_field("lambda_estimate", int'(want.lambda), int'(got.lambda));
					check_field("slot_item_count", int'(want.count), int'(got.count));
				end
			end
		end
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: one unit of every resource, a single slot
		add_op(MODE_PROBE, 6'd0, 32'h0000_0000, 1'b1);
		add_op(MODE_PROBE, 6'd0, 32'hFFFF_FFFF, 1'b0);
		add_op(MODE_PROBE, 6'd1, 32'h0000_0000, 1'b1);
		add_op(MODE_INSERT, 6'd0, 32'h1111_1111, 1'b0);
		add_op(MODE_INSERT, 6'd0, 32'h1111_1111, 1'b1);
		add_op(MODE_INSERT, 6'd0, 32'hFFFF_FFFF, 1'b1);
		repeat (3)
			add_op(MODE_INSERT, 6'd0, 32'h0000_0000, 1'b1);
		add_op(MODE_INSERT, 6'd0, 32'h0000_0000, 1'b1);
		add_op(MODE_REMOVE, 6'd0, 32'h2222_2222, 1'b1);
		add_op(MODE_REMOVE, 6'd0, 32'h1111_1111, 1'b0);
		repeat (3)
			add_op(MODE_REMOVE, 6'd0, 32'h0000_0000, 1'b1);
		add_op(MODE_REMOVE, 6'd0, 32'h0000_0000, 1'b1);
		add_op(MODE_ENTER, 6'd0, 32'hFFFF_FFFF, 1'b0);
		add_op(MODE_ENTER, 6'd63, 32'hFFFF_FFFF, 1'b1);
		add_op(MODE_INSERT, 6'd0, 32'h0101_0101, 1'b1);
		add_op(MODE_CLR_SLOTS, 6'd63, 32'hFFFF_FFFF, 1'b1);
		add_op(MODE_PROBE, 6'd0, 32'h0000_0001, 1'b1);
		add_op(MODE_CLR_TOTALS, 6'd42, 32'hA5A5_A5A5, 1'b0);
		add_op(MODE_NOP_LO, 6'd0, 32'h5A5A_5A5A, 1'b1);
		add_op(MODE_NOP_HI, 6'd63, 32'hFFFF_FFFF, 1'b0);
		add_op(MODE_REMOVE, 6'd63, 32'h0000_0000, 1'b1);

		// no slot in range and no resource counted
		set_config(32'h0000_0000, 7'd0, 1'b0);
		add_random(60);

		set_config(32'hFFFF_FFFF, 7'd64, 1'b0);
		add_random(200);

		set_config($urandom, 7'd1, 1'b1);
		add_random(100);

		set_config($urandom, 7'd63, 1'b0);
		add_random(200);

		// pile up large totals for the lambda divide
		set_config(32'hF000_0001, 7'd64, 1'b1);
		repeat (BULK_ENTERS)
			add_op(MODE_ENTER, SLOT_W'($urandom_range(0, 63)), 32'hFFFF_FFFF, 1'b1);

		set_config(32'hFFFF_FFFF, 7'd64, 1'b0);
		add_random(200);

		set_config($urandom, TLEN_W'($urandom_range(1, 64)), 1'b0);
		add_random(80);

		wait_drained();
		repeat (40) @(posedge clk);
		if (error_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
